>>> rtl/cdtoc_pkg.sv
// Shared types, constants and word decode helpers for the CD TOC query engine.
// Used by cdtoc_mem, cdtoc_seq and cd_toc_query_engine.
package cdtoc_pkg;

  localparam int TABLE_DEPTH = 102;
  localparam int ADDR_W      = 7;
  localparam int WORD_W      = 32;
  localparam int FRAME_W     = 24;
  localparam int TRACK_W     = 8;
  localparam int NUM_W       = 7;

  localparam logic [3:0] CTRL_ABSENT = 4'hF;
  localparam int         CTRL_DATA_BIT = 2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // fetch steps: one table read each up to FS_NEXT; FS_DONE ends the fetch
  localparam logic [2:0] FS_LAST    = 3'd0;
  localparam logic [2:0] FS_FIRST   = 3'd1;
  localparam logic [2:0] FS_LEADOUT = 3'd2;
  localparam logic [2:0] FS_CUR     = 3'd3;
  localparam logic [2:0] FS_NEXT    = 3'd4;
  localparam logic [2:0] FS_DONE    = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_FETCH  = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  typedef struct packed {
    logic                we;
    logic [ADDR_W-1:0]   addr;
    logic [WORD_W-1:0]   wdata;
  } mem_req_t;

  typedef struct packed {
    logic               track_is_audio;
    logic [FRAME_W-1:0] start_address;
    logic [FRAME_W-1:0] end_address;
    logic [NUM_W-1:0]   last_audio_track;
  } result_t;

  function automatic logic word_absent(input logic [WORD_W-1:0] w);
    return w[31:28] == CTRL_ABSENT;
  endfunction

  function automatic logic word_audio(input logic [WORD_W-1:0] w);
    return !word_absent(w) && !w[28+CTRL_DATA_BIT];
  endfunction

  // track number held in a first/last record, zero when out of 1..max
  function automatic logic [NUM_W-1:0] rec_num(input logic [WORD_W-1:0] w,
                                               input logic [TRACK_W-1:0] max_trk);
    logic [TRACK_W-1:0] n;
    n = w[23:16];
    return (n != '0 && n <= max_trk) ? n[NUM_W-1:0] : '0;
  endfunction

endpackage

>>> rtl/cdtoc_mem.sv
// Table of contents word store: one port, registered read data.
// Depends on cdtoc_pkg; addresses past the table read as zero.
module cdtoc_mem (
  input  logic                       clk,
  input  cdtoc_pkg::mem_req_t        req,
  output logic [cdtoc_pkg::WORD_W-1:0] rdata
);

  logic [cdtoc_pkg::WORD_W-1:0] words [0:cdtoc_pkg::TABLE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (req.we && req.addr < cdtoc_pkg::ADDR_W'(cdtoc_pkg::TABLE_DEPTH)) begin
      words[req.addr] <= req.wdata;
    end
    if (req.addr < cdtoc_pkg::ADDR_W'(cdtoc_pkg::TABLE_DEPTH)) begin
      rdata <= words[req.addr];
    end else begin
      rdata <= '0;
    end
  end

endmodule

>>> rtl/cdtoc_seq.sv
// Query sequencer: walks the record words, the asked track and the track range
// through the single table read port. Depends on cdtoc_pkg and drives cdtoc_mem.
module cdtoc_seq #(
  parameter int MAX_TRACKS         = 99,
  parameter int FIRST_RECORD_INDEX = 99,
  parameter int LAST_RECORD_INDEX  = 100,
  parameter int LEADOUT_INDEX      = 101
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          op,
  input  logic [cdtoc_pkg::ADDR_W-1:0]  word_index,
  input  logic [cdtoc_pkg::WORD_W-1:0]  word_data,
  input  logic [cdtoc_pkg::TRACK_W-1:0] track,
  input  logic                          out_free,
  output cdtoc_pkg::mem_req_t           mem_req,
  input  logic [cdtoc_pkg::WORD_W-1:0]  rdata,
  output logic                          res_valid,
  output cdtoc_pkg::result_t            res
);

  localparam logic [cdtoc_pkg::TRACK_W-1:0] MaxTrk = cdtoc_pkg::TRACK_W'(MAX_TRACKS);

  cdtoc_pkg::state_t state, state_next;

  logic [2:0]                          step;
  logic [2:0]                          ftag;
  logic                                fpend;
  logic [cdtoc_pkg::TRACK_W-1:0]       trk;
  logic [cdtoc_pkg::NUM_W-1:0]         first_num;
  logic [cdtoc_pkg::NUM_W-1:0]         last_num;
  logic [cdtoc_pkg::FRAME_W-1:0]       leadout_fr;
  logic [cdtoc_pkg::WORD_W-1:0]        cur_w;
  logic [cdtoc_pkg::WORD_W-1:0]        nxt_w;
  logic [cdtoc_pkg::NUM_W-1:0]         k;
  logic                                spend;
  logic [cdtoc_pkg::NUM_W-1:0]         spend_k;
  logic [cdtoc_pkg::NUM_W-1:0]         best;

  logic                                trk_ok;
  logic                                scan_issue;
  logic                                range_bad;
  logic [cdtoc_pkg::ADDR_W-1:0]        fetch_addr;
  logic                                accept;

  assign accept     = in_valid && in_ready;
  assign in_ready   = (state == cdtoc_pkg::S_IDLE);
  assign trk_ok     = (trk != '0) && (trk <= MaxTrk);
  assign scan_issue = (k <= last_num);
  assign range_bad  = (first_num == '0) || (last_num == '0) || (first_num > last_num);

  always_comb begin
    unique case (step)
      cdtoc_pkg::FS_LAST:    fetch_addr = cdtoc_pkg::ADDR_W'(LAST_RECORD_INDEX);
      cdtoc_pkg::FS_FIRST:   fetch_addr = cdtoc_pkg::ADDR_W'(FIRST_RECORD_INDEX);
      cdtoc_pkg::FS_LEADOUT: fetch_addr = cdtoc_pkg::ADDR_W'(LEADOUT_INDEX);
      cdtoc_pkg::FS_CUR:     fetch_addr = trk_ok ? trk[cdtoc_pkg::ADDR_W-1:0] - 1'b1 : '0;
      cdtoc_pkg::FS_NEXT:    fetch_addr = trk_ok ? trk[cdtoc_pkg::ADDR_W-1:0] : '0;
      default:               fetch_addr = '0;
    endcase
  end

  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.wdata = word_data;
    mem_req.addr  = '0;
    unique case (state)
      cdtoc_pkg::S_IDLE: begin
        mem_req.addr = word_index;
        mem_req.we   = accept && (op == cdtoc_pkg::OP_WRITE);
      end
      cdtoc_pkg::S_FETCH:  mem_req.addr = fetch_addr;
      cdtoc_pkg::S_SCAN:   mem_req.addr = k - 1'b1;
      cdtoc_pkg::S_FINISH: mem_req.addr = '0;
      default:             mem_req.addr = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cdtoc_pkg::S_IDLE: begin
        if (accept && op == cdtoc_pkg::OP_QUERY) begin
          state_next = cdtoc_pkg::S_FETCH;
        end
      end
      cdtoc_pkg::S_FETCH: begin
        if (step == cdtoc_pkg::FS_DONE) begin
          state_next = range_bad ? cdtoc_pkg::S_FINISH : cdtoc_pkg::S_SCAN;
        end
      end
      cdtoc_pkg::S_SCAN: begin
        if (!scan_issue && !spend) begin
          state_next = cdtoc_pkg::S_FINISH;
        end
      end
      cdtoc_pkg::S_FINISH: begin
        if (out_free) begin
          state_next = cdtoc_pkg::S_IDLE;
        end
      end
      default: state_next = cdtoc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdtoc_pkg::S_IDLE;
      fpend <= 1'b0;
      spend <= 1'b0;
      step  <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        cdtoc_pkg::S_IDLE: begin
          step  <= cdtoc_pkg::FS_LAST;
          fpend <= 1'b0;
          spend <= 1'b0;
        end
        cdtoc_pkg::S_FETCH: begin
          fpend <= (step != cdtoc_pkg::FS_DONE);
          if (step != cdtoc_pkg::FS_DONE) begin
            step <= step + 1'b1;
          end
        end
        cdtoc_pkg::S_SCAN: spend <= scan_issue;
        cdtoc_pkg::S_FINISH: spend <= 1'b0;
        default: spend <= 1'b0;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      trk  <= track;
      best <= '0;
    end
    if (state == cdtoc_pkg::S_FETCH) begin
      ftag <= step;
      if (fpend) begin
        unique case (ftag)
          cdtoc_pkg::FS_LAST:    last_num   <= cdtoc_pkg::rec_num(rdata, MaxTrk);
          cdtoc_pkg::FS_FIRST:   first_num  <= cdtoc_pkg::rec_num(rdata, MaxTrk);
          cdtoc_pkg::FS_LEADOUT: leadout_fr <= rdata[cdtoc_pkg::FRAME_W-1:0];
          cdtoc_pkg::FS_CUR:     cur_w      <= rdata;
          cdtoc_pkg::FS_NEXT:    nxt_w      <= rdata;
          default:               nxt_w      <= nxt_w;
        endcase
      end
      if (step == cdtoc_pkg::FS_DONE) begin
        k <= first_num;
      end
    end
    if (state == cdtoc_pkg::S_SCAN) begin
      if (scan_issue) begin
        k <= k + 1'b1;
      end
      spend_k <= k;
      if (spend && cdtoc_pkg::word_audio(rdata)) begin
        best <= spend_k;
      end
    end
  end

  assign res_valid = (state == cdtoc_pkg::S_FINISH) && out_free;

  always_comb begin
    res.track_is_audio   = trk_ok && cdtoc_pkg::word_audio(cur_w);
    res.start_address    = (trk_ok && !cdtoc_pkg::word_absent(cur_w)) ?
                           cur_w[cdtoc_pkg::FRAME_W-1:0] : '0;
    res.last_audio_track = best;
    if (!trk_ok || cdtoc_pkg::word_absent(cur_w) || last_num == '0) begin
      res.end_address = '0;
    end else if (trk >= {1'b0, last_num} || cdtoc_pkg::word_absent(nxt_w)) begin
      res.end_address = leadout_fr;
    end else begin
      res.end_address = nxt_w[cdtoc_pkg::FRAME_W-1:0];
    end
  end

endmodule

>>> rtl/cd_toc_query_engine.sv
// CD table of contents query engine, top level: stream ports and result register.
// Writes are taken back to back, one per cycle, while idle. A query reads the record
// words and the asked track's words, then scans each track from first to last record,
// and shows its result as it frees the input; a bad record range skips the scan. The
// single table read port is walked one word per cycle; a held result stalls.
// rst is synchronous: clears the sequencer and the result valid; table is undefined.
module cd_toc_query_engine #(
  parameter int MAX_TRACKS         = 99,
  parameter int FIRST_RECORD_INDEX = 99,
  parameter int LAST_RECORD_INDEX  = 100,
  parameter int LEADOUT_INDEX      = 101
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // word_index[6:0], word_data[38:7], track[46:39], zero pad
  input  logic        s_tuser,  // op: 0 write, 1 query
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata   // track_is_audio[0], start_address[24:1],
                                // end_address[48:25], last_audio_track[55:49]
);

  cdtoc_pkg::mem_req_t           mem_req;
  logic [cdtoc_pkg::WORD_W-1:0]  rdata;
  logic                          res_valid;
  cdtoc_pkg::result_t            res;
  logic                          out_free;

  assign out_free = !m_tvalid || m_tready;

  cdtoc_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  cdtoc_seq #(
    .MAX_TRACKS         (MAX_TRACKS),
    .FIRST_RECORD_INDEX (FIRST_RECORD_INDEX),
    .LAST_RECORD_INDEX  (LAST_RECORD_INDEX),
    .LEADOUT_INDEX      (LEADOUT_INDEX)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .op         (s_tuser),
    .word_index (s_tdata[6:0]),
    .word_data  (s_tdata[38:7]),
    .track      (s_tdata[46:39]),
    .out_free   (out_free),
    .mem_req    (mem_req),
    .rdata      (rdata),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tdata <= {res.last_audio_track, res.end_address, res.start_address,
                  res.track_is_audio};
    end
  end

endmodule

>>> rtl/cdtoc_checker.sv
// Port-level checks for cd_toc_query_engine, attached by the bind below.
// Depends only on the top level's ports and MAX_TRACKS.
module cdtoc_checker #(
  parameter int MAX_TRACKS = 99
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata
);

  // no result may appear straight out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a query occupies the block
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser) |=> !s_tready)
    else $error("input ready right after a query transaction");

  // a write leaves the input ready in the cycle after it
  a_write_fast: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !s_tuser) |=> s_tready)
    else $error("input not ready after a write transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  a_last_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[55:49] <= 7'(MAX_TRACKS)))
    else $error("last audio track above track limit");

endmodule

bind cd_toc_query_engine cdtoc_checker #(.MAX_TRACKS(MAX_TRACKS)) u_cdtoc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
